FILE: src/fsd_pkg.sv
package fsd_pkg;

  localparam int unsigned DutyW  = 7;
  localparam int unsigned TickW  = 16;
  localparam int unsigned PulseW = 32;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  localparam logic [DutyW-1:0] DutyThresholdRst = 7'd30;
  localparam logic [TickW-1:0] WindowTicksRst   = 16'd30;
  localparam logic [TickW-1:0] MinPulsesRst     = 16'd5;
  localparam logic [TickW-1:0] RetryTicksRst    = 16'd100;

  typedef enum logic [ModeW-1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_MONITOR = 2'd1,
    MODE_FAULT   = 2'd2,
    MODE_SEVERE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_DUTY_THRESHOLD = 2'd0,
    REG_WINDOW_TICKS   = 2'd1,
    REG_MIN_PULSES     = 2'd2,
    REG_RETRY_TICKS    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DutyW-1:0] duty_threshold;
    logic [TickW-1:0] window_ticks;
    logic [TickW-1:0] min_pulses;
    logic [TickW-1:0] retry_ticks;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic [DutyW-1:0]  requested_duty;
    logic [PulseW-1:0] pulse_total;
  } item_t;

  typedef struct packed {
    logic [DutyW-1:0] drive_duty;
    mode_e            mode_now;
    logic             stalled;
  } res_t;

endpackage

FILE: src/fsd_in_if.sv
interface fsd_in_if import fsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [DutyW-1:0]  requested_duty;
  logic [PulseW-1:0] pulse_total;

  modport source (output valid, action, requested_duty, pulse_total, input ready);
  modport sink   (input valid, action, requested_duty, pulse_total, output ready);
endinterface

FILE: src/fsd_out_if.sv
interface fsd_out_if import fsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] drive_duty;
  logic [ModeW-1:0] mode_now;
  logic             stalled;

  modport source (output valid, drive_duty, mode_now, stalled, input ready);
  modport sink   (input valid, drive_duty, mode_now, stalled, output ready);
endinterface

FILE: src/fsd_cfg_regs.sv
module fsd_cfg_regs import fsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_threshold <= DutyThresholdRst;
      cfg_q.window_ticks   <= WindowTicksRst;
      cfg_q.min_pulses     <= MinPulsesRst;
      cfg_q.retry_ticks    <= RetryTicksRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_DUTY_THRESHOLD: cfg_q.duty_threshold <= pwdata[DutyW-1:0];
        REG_WINDOW_TICKS:   cfg_q.window_ticks   <= pwdata[TickW-1:0];
        REG_MIN_PULSES:     cfg_q.min_pulses     <= pwdata[TickW-1:0];
        REG_RETRY_TICKS:    cfg_q.retry_ticks    <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DUTY_THRESHOLD: prdata = {{(ApbDataW-DutyW){1'b0}}, cfg_q.duty_threshold};
      REG_WINDOW_TICKS:   prdata = {{(ApbDataW-TickW){1'b0}}, cfg_q.window_ticks};
      REG_MIN_PULSES:     prdata = {{(ApbDataW-TickW){1'b0}}, cfg_q.min_pulses};
      REG_RETRY_TICKS:    prdata = {{(ApbDataW-TickW){1'b0}}, cfg_q.retry_ticks};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/fsd_step.sv
module fsd_step import fsd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_en_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  mode_e             mode_q, mode_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic              retry_q, retry_d;
  logic [PulseW-1:0] wstart_q, wstart_d;
  logic [TickW-1:0]  tick_inc;
  logic [PulseW-1:0] pulse_diff;
  logic              duty_high;
  logic [DutyW-1:0]  drive;

  assign tick_inc   = tick_q + 1'b1;
  assign pulse_diff = item_i.pulse_total - wstart_q;
  assign duty_high  = item_i.requested_duty > cfg_i.duty_threshold;

  always_comb begin
    mode_d   = mode_q;
    tick_d   = tick_q;
    retry_d  = retry_q;
    wstart_d = wstart_q;
    drive    = '0;
    if (item_i.action) begin
      mode_d  = MODE_NORMAL;
      tick_d  = '0;
      retry_d = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_NORMAL: begin
          if (duty_high) begin
            mode_d   = MODE_MONITOR;
            wstart_d = item_i.pulse_total;
            tick_d   = '0;
          end
          drive = item_i.requested_duty;
        end
        MODE_MONITOR: begin
          if (!duty_high) begin
            mode_d = MODE_NORMAL;
            drive  = item_i.requested_duty;
          end else begin
            tick_d = tick_inc;
            // pulse check wins over window expiry on the last tick
            if (pulse_diff >= {{(PulseW-TickW){1'b0}}, cfg_i.min_pulses}) begin
              mode_d = MODE_NORMAL;
              drive  = item_i.requested_duty;
            end else if (tick_inc >= cfg_i.window_ticks) begin
              mode_d = retry_q ? MODE_SEVERE : MODE_FAULT;
              tick_d = '0;
            end else begin
              drive = item_i.requested_duty;
            end
          end
        end
        MODE_FAULT: begin
          // duty drops are ignored here; keep counting toward the retry
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.retry_ticks) begin
            retry_d  = 1'b1;
            mode_d   = MODE_MONITOR;
            wstart_d = item_i.pulse_total;
            tick_d   = '0;
          end
        end
        MODE_SEVERE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      tick_q  <= '0;
      retry_q <= 1'b0;
    end else if (step_en_i) begin
      mode_q  <= mode_d;
      tick_q  <= tick_d;
      retry_q <= retry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en_i) begin
      wstart_q <= wstart_d;
    end
  end

  assign res_o.drive_duty = drive;
  assign res_o.mode_now   = mode_d;
  assign res_o.stalled    = (mode_d == MODE_FAULT) || (mode_d == MODE_SEVERE);

`ifndef SYNTHESIS
  a_severe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && mode_q == MODE_SEVERE && !item_i.action |=> mode_q == MODE_SEVERE)
    else $error("severe mode left without a manual clear");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && item_i.action |=> mode_q == MODE_NORMAL && tick_q == '0 && !retry_q)
    else $error("manual clear did not restore normal state");

  a_severe_after_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_SEVERE |-> retry_q)
    else $error("severe mode without a used retry");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> $stable(mode_q) && $stable(tick_q) && $stable(retry_q))
    else $error("state moved without a step");
`endif

endmodule

FILE: src/fan_stall_detector.sv
// Channel   Direction  Payload                                   Transfer when
// in_i      sink       action, requested_duty, pulse_total       valid && ready
// out_o     source     drive_duty, mode_now, stalled             valid && ready
// apb       slave      4 registers at byte addresses 0,4,8,12    psel&&penable&&pwrite
//
// Pipeline: the input register takes the item at the input transfer, and the result
// register takes the result when the item advances; one item per cycle is sustained
// while out_o.ready stays high, with the combinational mode update between the two.
// Reset: rst_ni clears mode, tick count, retry flag and both valid flags and
// loads the register defaults; the window start register needs no reset.
// Stalls: with out_o.ready low the result register holds and the input register
// still takes one more item, then in_i.ready drops until the result moves on.
module fan_stall_detector import fsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  fsd_in_if.sink              in_i,
  fsd_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_vld_q;
  res_t  res;
  res_t  res_q;
  logic  out_vld_q;
  logic  advance;
  logic  in_take;

  fsd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the held item into the result register when that register is free
  // or its content is being transferred out in this cycle.
  assign advance = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action         <= in_i.action;
      item_q.requested_duty <= in_i.requested_duty;
      item_q.pulse_total    <= in_i.pulse_total;
    end
  end

  // Mode update runs on the held item; state commits only on advance.
  fsd_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.drive_duty = res_q.drive_duty;
  assign out_o.mode_now   = res_q.mode_now;
  assign out_o.stalled    = res_q.stalled;

endmodule

FILE: sim/tb_fan_stall_detector.sv
module tb_fan_stall_detector;
  import fsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Stop the run here if the tick stream stalls for good.
  localparam int unsigned CycleLimit = 400000;
  // Let the result pipeline settle before a register write or the end.
  localparam int unsigned SettleCycles = 4;
  // Show this many failures in full, count the rest.
  localparam int unsigned ShowFails = 10;

  logic clk;
  logic rst_n;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  fsd_in_if  in_if ();
  fsd_out_if out_if ();

  fan_stall_detector i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Ticks waiting for the driver, and the supervisor outputs they must produce.
  item_t pending_ticks[$];
  res_t  expected_results[$];

  // Shadow copy of the register file, updated only when a write completes.
  cfg_t shadow_cfg;

  // Shadow supervisor state.
  mode_e             sv_mode;
  logic [PulseW-1:0] sv_window_start;
  logic [TickW-1:0]  sv_tick_cnt;
  logic              sv_retry_used;

  // Hall counter and spin state of the simulated fan.
  logic [PulseW-1:0] hall_cnt;
  bit                fan_spinning;

  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  // Work out the supervisor output for one accepted tick and advance the
  // shadow state. Mirrors the mode update of the block.
  function automatic res_t predict_fan_result(item_t it);
    res_t              r;
    logic [DutyW-1:0]  drive;
    logic [PulseW-1:0] since_start;
    drive = '0;
    if (it.action) begin
      // Manual clear: back to normal, retry allowance restored.
      sv_mode       = MODE_NORMAL;
      sv_tick_cnt   = '0;
      sv_retry_used = 1'b0;
    end else begin
      case (sv_mode)
        MODE_NORMAL: begin
          // Open a window on the tick that crosses the threshold; that tick
          // does not count towards the window.
          if (it.requested_duty > shadow_cfg.duty_threshold) begin
            sv_mode         = MODE_MONITOR;
            sv_window_start = it.pulse_total;
            sv_tick_cnt     = '0;
          end
          drive = it.requested_duty;
        end
        MODE_MONITOR: begin
          if (it.requested_duty <= shadow_cfg.duty_threshold) begin
            sv_mode = MODE_NORMAL;
            drive   = it.requested_duty;
          end else begin
            sv_tick_cnt = sv_tick_cnt + 1'b1;
            // Pulse difference wraps modulo 2^32; the pulse check wins over
            // an expiring window.
            since_start = it.pulse_total - sv_window_start;
            if (since_start >= PulseW'(shadow_cfg.min_pulses)) begin
              sv_mode = MODE_NORMAL;
              drive   = it.requested_duty;
            end else if (sv_tick_cnt >= shadow_cfg.window_ticks) begin
              sv_mode     = sv_retry_used ? MODE_SEVERE : MODE_FAULT;
              sv_tick_cnt = '0;
            end else begin
              drive = it.requested_duty;
            end
          end
        end
        MODE_FAULT: begin
          // Duty drops do not matter here; only the retry timer runs.
          sv_tick_cnt = sv_tick_cnt + 1'b1;
          if (sv_tick_cnt >= shadow_cfg.retry_ticks) begin
            sv_retry_used   = 1'b1;
            sv_mode         = MODE_MONITOR;
            sv_window_start = it.pulse_total;
            sv_tick_cnt     = '0;
          end
        end
        default: begin
        end
      endcase
    end
    r.drive_duty = drive;
    r.mode_now   = sv_mode;
    r.stalled    = (sv_mode == MODE_FAULT) || (sv_mode == MODE_SEVERE);
    return r;
  endfunction

  // Mostly no idle, sometimes a short gap, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  // ---------------------------------------------------------------------------
  // Tick driver: hold valid until the transfer, then predict from what the
  // block actually took.
  // ---------------------------------------------------------------------------
  int unsigned src_gap;
  int unsigned src_calm;

  always @(posedge clk) begin : drive_ticks
    bit    offering;
    item_t next_tick;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      src_gap  = 0;
      src_calm = 0;
    end else begin
      offering = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        next_tick.action         = in_if.action;
        next_tick.requested_duty = in_if.requested_duty;
        next_tick.pulse_total    = in_if.pulse_total;
        expected_results.push_back(predict_fan_result(next_tick));
        offering = 1'b0;
        // Choose the idle time before the next tick; calm stretches have none.
        if (src_calm > 0) begin
          src_calm--;
          src_gap = 0;
        end else begin
          if ($urandom_range(0, 49) == 0) src_calm = 40;
          src_gap = pick_gap();
        end
      end
      if (!offering) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_ticks.size() > 0) begin
          next_tick = pending_ticks.pop_front();
          in_if.action         <= next_tick.action;
          in_if.requested_duty <= next_tick.requested_duty;
          in_if.pulse_total    <= next_tick.pulse_total;
          offering = 1'b1;
        end
      end
      in_if.valid <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // Result ready: random gaps after each transfer, plus two long hold-offs
  // while ticks keep coming, so the block fills up and drops in_i.ready.
  // ---------------------------------------------------------------------------
  int unsigned snk_gap;
  int unsigned snk_calm;
  int unsigned snk_hold_left;
  int unsigned snk_hold_idx;
  int unsigned results_taken;
  int unsigned hold_marks[2] = '{250, 700};

  always @(posedge clk) begin : drive_ready
    bit take;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      snk_gap       = 0;
      snk_calm      = 0;
      snk_hold_left = 0;
      snk_hold_idx  = 0;
      results_taken = 0;
    end else begin
      take = 1'b1;
      if (out_if.valid && out_if.ready) begin
        results_taken++;
        if (snk_calm > 0) begin
          snk_calm--;
        end else begin
          if ($urandom_range(0, 49) == 0) snk_calm = 40;
          snk_gap = pick_gap();
        end
      end
      if (snk_hold_left > 0) begin
        snk_hold_left--;
        take = 1'b0;
      end else if (snk_hold_idx < 2 && results_taken >= hold_marks[snk_hold_idx]) begin
        snk_hold_left = $urandom_range(250, 350);
        snk_hold_idx++;
        take = 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        take = 1'b0;
      end
      out_if.ready <= take;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= ShowFails)
          $display("unexpected result: drive %0d mode %0d stalled %0b",
                   out_if.drive_duty, out_if.mode_now, out_if.stalled);
      end else begin
        want = expected_results.pop_front();
        if (out_if.drive_duty !== want.drive_duty || out_if.mode_now !== want.mode_now ||
            out_if.stalled !== want.stalled) begin
          fail_cnt++;
          if (fail_cnt <= ShowFails)
            $display("mismatch: drive %0d/%0d mode %0d/%0d stalled %0b/%0b (exp/act)",
                     want.drive_duty, out_if.drive_duty, want.mode_now, out_if.mode_now,
                     want.stalled, out_if.stalled);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_fan_stall_detector failed");
      $finish;
    end
  end

  // Write one register over APB: setup cycle, then access cycle.
  task automatic apb_write(input reg_idx_e idx, input logic [ApbDataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DUTY_THRESHOLD: shadow_cfg.duty_threshold = value[DutyW-1:0];
      REG_WINDOW_TICKS:   shadow_cfg.window_ticks   = value[TickW-1:0];
      REG_MIN_PULSES:     shadow_cfg.min_pulses     = value[TickW-1:0];
      REG_RETRY_TICKS:    shadow_cfg.retry_ticks    = value[TickW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int unsigned thr, input int unsigned win,
                              input int unsigned minp, input int unsigned retry);
    apb_write(REG_DUTY_THRESHOLD, thr);
    apb_write(REG_WINDOW_TICKS, win);
    apb_write(REG_MIN_PULSES, minp);
    apb_write(REG_RETRY_TICKS, retry);
  endtask

  task automatic push_tick(input logic action, input logic [DutyW-1:0] duty,
                           input logic [PulseW-1:0] pulses);
    item_t it;
    it.action         = action;
    it.requested_duty = duty;
    it.pulse_total    = pulses;
    pending_ticks.push_back(it);
  endtask

  // Hold the stimulus until every tick is taken and every result is back.
  // Check between edges so the driver's updates of this edge are visible.
  task automatic drain();
    @(negedge clk);
    while (pending_ticks.size() > 0 || in_if.valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Queue a fan run: mostly ticks from a fan that spins or stalls for
  // stretches, the rest clears and ticks with random content.
  task automatic queue_fan_run(input int unsigned n);
    int unsigned thr;
    int unsigned hi;
    int unsigned rate;
    int unsigned flip_den;
    int unsigned r;
    logic [PulseW-1:0] inc;
    item_t       it;
    thr      = 32'(shadow_cfg.duty_threshold);
    rate     = (shadow_cfg.min_pulses / shadow_cfg.window_ticks) * 2 + 2;
    flip_den = shadow_cfg.window_ticks + shadow_cfg.retry_ticks;
    if (flip_den > 200) flip_den = 200;
    flip_den += 4;
    hall_cnt     = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFF0;
    fan_spinning = 1'b1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, flip_den) == 0) fan_spinning = !fan_spinning;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // Noise: any field value, any pulse jump.
        it.action         = 1'($urandom_range(0, 1));
        it.requested_duty = DutyW'($urandom_range(0, 127));
        it.pulse_total    = $urandom;
      end else if (r < 7) begin
        it.action         = 1'b1;
        it.requested_duty = DutyW'($urandom_range(0, 127));
        it.pulse_total    = $urandom;
      end else begin
        it.action = 1'b0;
        inc = fan_spinning ? $urandom_range(0, rate) : 32'($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 19) == 0) inc = $urandom_range(0, 2 * shadow_cfg.min_pulses);
        hall_cnt       = hall_cnt + inc;
        it.pulse_total = hall_cnt;
        if (thr < 127 && $urandom_range(0, 99) < 85) begin
          hi = (thr < 100 && $urandom_range(0, 29) != 0) ? 100 : 127;
          it.requested_duty = DutyW'($urandom_range(thr + 1, hi));
        end else begin
          it.requested_duty = DutyW'($urandom_range(0, thr));
        end
      end
      pending_ticks.push_back(it);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.action   = 1'b0;
    in_if.requested_duty = '0;
    in_if.pulse_total    = '0;
    out_if.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    fail_cnt       = 0;
    cycle_cnt      = 0;
    shadow_cfg.duty_threshold = DutyThresholdRst;
    shadow_cfg.window_ticks   = WindowTicksRst;
    shadow_cfg.min_pulses     = MinPulsesRst;
    shadow_cfg.retry_ticks    = RetryTicksRst;
    sv_mode         = MODE_NORMAL;
    sv_window_start = '0;
    sv_tick_cnt     = '0;
    sv_retry_used   = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Run on the reset register values first.
    queue_fan_run(150);
    drain();

    // Directed walk through every mode with a short window and retry.
    program_regs(50, 3, 4, 2);
    push_tick(1'b0, 7'd0, 32'd0);              // idle fan
    push_tick(1'b0, 7'd50, 32'd0);             // duty equal to threshold: no window
    push_tick(1'b0, 7'd51, 32'd100);           // window opens
    push_tick(1'b0, 7'd51, 32'd103);           // too few pulses so far
    push_tick(1'b0, 7'd30, 32'd103);           // duty drop while monitoring
    push_tick(1'b0, 7'd100, 32'd200);          // window opens
    push_tick(1'b0, 7'd100, 32'd201);
    push_tick(1'b0, 7'd100, 32'd202);
    push_tick(1'b0, 7'd100, 32'd204);          // enough pulses on the last window tick
    push_tick(1'b0, 7'd127, 32'd300);          // duty above 100 passes through
    push_tick(1'b0, 7'd127, 32'd300);
    push_tick(1'b0, 7'd127, 32'd300);
    push_tick(1'b0, 7'd127, 32'd300);          // window expires: fault
    push_tick(1'b0, 7'd0, 32'd300);            // duty drop in fault is ignored
    push_tick(1'b0, 7'd0, 32'd300);            // retry opens a new window
    push_tick(1'b0, 7'd90, 32'd300);
    push_tick(1'b0, 7'd90, 32'd300);
    push_tick(1'b0, 7'd90, 32'd300);           // second stall: severe
    push_tick(1'b0, 7'd90, 32'd5000);          // severe holds
    push_tick(1'b1, 7'd127, 32'hFFFF_FFFF);    // manual clear
    push_tick(1'b0, 7'd60, 32'hFFFF_FFFE);     // window opens near the wrap
    push_tick(1'b0, 7'd60, 32'h0000_0002);     // pulse difference wraps
    push_tick(1'b0, 7'd60, 32'hFFFF_FFFF);
    push_tick(1'b1, 7'd0, 32'd0);              // manual clear while monitoring
    drain();

    // Register extremes, low then high.
    program_regs(0, 1, 1, 1);
    queue_fan_run(150);
    drain();
    program_regs(100, 65535, 65535, 65535);
    queue_fan_run(80);
    drain();

    // A fixed setting, then random ones, mostly short windows so faults and retries are frequent.
    program_regs(100, 2, 3, 2);
    queue_fan_run(180);
    drain();
    for (int p = 0; p < 3; p++) begin
      program_regs($urandom_range(0, 100),
                   (p == 1) ? $urandom_range(20, 60) : $urandom_range(1, 8),
                   $urandom_range(1, 12), $urandom_range(1, 8));
      queue_fan_run(180);
      drain();
    end

    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("tb_fan_stall_detector passed");
    end else begin
      $display("tb_fan_stall_detector failed");
    end
    $finish;
  end

endmodule
